// ===== design/trlp_pkg.sv =====
// Shared types and constants for the track range list parser.
// Used by trlp_store, track_range_list_parser, trlp_checker and the testbench; no dependencies.
package trlp_pkg;

    // Command codes carried in the input beat
    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_CHAR  = 2'd1;
    localparam logic [1:0] CMD_END   = 2'd2;
    localparam logic [1:0] CMD_READ  = 2'd3;

    // Status codes carried in the output beat
    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_INVALID   = 2'd1;
    localparam logic [1:0] STAT_NOT_FOUND = 2'd2;
    localparam logic [1:0] STAT_FULL      = 2'd3;

    // Character codes
    localparam logic [7:0] CH_A     = 8'h61;
    localparam logic [7:0] CH_L     = 8'h6C;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;

    // Saturation value of the number accumulator
    localparam logic [8:0] ACC_MAX = 9'd511;

    // Access request from the sequencer to the list and presence memories
    typedef struct packed {
        logic       pm_we;
        logic [7:0] pm_addr;
        logic       pm_wbit;
        logic       list_we;
        logic [7:0] list_waddr;
        logic [7:0] list_wdata;
        logic [7:0] list_raddr;
    } trlp_store_req_t;

endpackage

// ===== design/trlp_store.sv =====
// List memory and presence-map memory of the track range list parser.
// Depends on trlp_pkg for the request struct; both reads are registered.
module trlp_store #(
    parameter int LIST_DEPTH = 255
) (
    input  logic                     aclk,
    input  trlp_pkg::trlp_store_req_t req,
    output logic                     pm_rdata,
    output logic [7:0]               list_rdata
);

    localparam int IDX_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

    logic       pm_mem [0:255];
    logic [7:0] list_mem [0:LIST_DEPTH-1];

    // Presence map: one write and one read port, registered read
    always_ff @(posedge aclk) begin
        if (req.pm_we) begin
            pm_mem[req.pm_addr] <= req.pm_wbit;
        end
        pm_rdata <= pm_mem[req.pm_addr];
    end

    // Track list: write at the fill position, registered read at the beat index
    always_ff @(posedge aclk) begin
        if (req.list_we) begin
            list_mem[req.list_waddr[IDX_W-1:0]] <= req.list_wdata;
        end
        if (req.list_raddr < 8'(LIST_DEPTH)) begin
            list_rdata <= list_mem[req.list_raddr[IDX_W-1:0]];
        end else begin
            list_rdata <= '0;
        end
    end

endmodule

// ===== design/track_range_list_parser.sv =====
// Track range list parser: character decoder and a track stepper that expands ranges
// against the presence map one track at a time. Depends on trlp_pkg and trlp_store.
// A clear sweeps the whole presence map; a list read waits on the registered list read;
// an expansion reads the presence bit of each track and adds the new ones to the list.
// One item at a time; s_tready is low while an item is in work. The result register
// frees the input side. Reset: a pass over all 256 entries clears the presence map, s_tready low.
module track_range_list_parser #(
    parameter int LIST_DEPTH = 255
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration: highest existing track number
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,
    // input beat
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [1:0] command, [9:2] char_code, [17:10] read_index
    // result beat
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // [1:0] status, [9:2] track_count, [17:10] entry_track
);

    typedef enum logic [2:0] {
        S_INIT, S_IDLE, S_CLEAR, S_LIST_RD, S_EXP_RD, S_EXP_CHK, S_FOLLOW, S_DONE
    } state_t;

    typedef enum logic [2:0] {
        PH_START, PH_FIRST, PH_IN_START, PH_AFTER_START,
        PH_EXPECT_END, PH_IN_END, PH_DELIM, PH_DONE
    } phase_t;

    // Action taken in S_FOLLOW once a range expansion or an end beat is through
    typedef enum logic [1:0] {
        FL_AFTER_START, FL_DELIM, FL_END
    } follow_t;

    state_t      state_reg, state_next;
    phase_t      phase_reg, phase_next;
    follow_t     follow_reg, follow_next;
    logic [7:0]  top_track_reg, top_track_next;
    logic [7:0]  count_reg, count_next;
    logic [8:0]  acc_reg, acc_next;
    logic [7:0]  rs_reg, rs_next;
    logic [1:0]  err_reg, err_next;
    logic [1:0]  kp_reg, kp_next;
    logic [7:0]  char_reg, char_next;
    logic [7:0]  idx_reg, idx_next;
    logic        is_rd_reg, is_rd_next;
    logic [7:0]  t_reg, t_next;
    logic [7:0]  end_reg, end_next;
    logic        up_reg, up_next;
    logic [7:0]  sweep_reg, sweep_next;
    logic        m_valid_reg, m_valid_next;
    logic [23:0] m_data_reg, m_data_next;

    trlp_pkg::trlp_store_req_t req;
    logic       pm_rdata;
    logic [7:0] list_rdata;

    logic [1:0]  in_cmd;
    logic [7:0]  in_char;
    logic [7:0]  in_idx;
    logic        c_space, c_digit;
    logic [3:0]  c_dval;
    logic [12:0] acc_prod;
    logic [8:0]  acc_sat;
    logic        acc_ok;
    logic [7:0]  entry;
    logic        add_new;

    function automatic logic is_space(input logic [7:0] c);
        return (c == trlp_pkg::CH_SPACE) || (c >= trlp_pkg::CH_TAB && c <= trlp_pkg::CH_CR);
    endfunction

    assign in_cmd  = s_tdata[1:0];
    assign in_char = s_tdata[9:2];
    assign in_idx  = s_tdata[17:10];

    // Character classes and the next accumulator value (x10 plus digit, saturating)
    assign c_space  = is_space(in_char);
    assign c_digit  = (in_char >= trlp_pkg::CH_ZERO) && (in_char <= trlp_pkg::CH_NINE);
    assign c_dval   = 4'(in_char - trlp_pkg::CH_ZERO);
    assign acc_prod = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0} + {9'd0, c_dval};
    assign acc_sat  = (acc_prod > {4'd0, trlp_pkg::ACC_MAX}) ? trlp_pkg::ACC_MAX
                                                             : acc_prod[8:0];
    assign acc_ok   = (acc_reg != 9'd0) && (acc_reg <= {1'b0, top_track_reg});

    assign entry    = (is_rd_reg && (idx_reg < count_reg)) ? list_rdata : 8'd0;
    assign add_new  = (t_reg != 8'd0) && !pm_rdata;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    trlp_store #(
        .LIST_DEPTH(LIST_DEPTH)
    ) u_store (
        .aclk      (aclk),
        .req       (req),
        .pm_rdata  (pm_rdata),
        .list_rdata(list_rdata)
    );

    // Sequencer: decode beats, step the range expansion, load the result register
    always_comb begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        follow_next    = follow_reg;
        top_track_next = cfg_we ? cfg_wdata : top_track_reg;
        count_next     = count_reg;
        acc_next       = acc_reg;
        rs_next        = rs_reg;
        err_next       = err_reg;
        kp_next        = kp_reg;
        char_next      = char_reg;
        idx_next       = idx_reg;
        is_rd_next     = is_rd_reg;
        t_next         = t_reg;
        end_next       = end_reg;
        up_next        = up_reg;
        sweep_next     = sweep_reg;
        m_data_next    = m_data_reg;
        m_valid_next   = m_valid_reg && !m_tready;

        req            = '0;
        req.pm_addr    = t_reg;
        req.list_waddr = count_reg;
        req.list_wdata = t_reg;
        req.list_raddr = idx_reg;

        case (state_reg)
            S_INIT, S_CLEAR: begin
                // Sweep the presence map to zero
                req.pm_we   = 1'b1;
                req.pm_addr = sweep_reg;
                sweep_next  = sweep_reg + 8'd1;
                if (sweep_reg == 8'hFF) begin
                    state_next = (state_reg == S_INIT) ? S_IDLE : S_DONE;
                end
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    char_next  = in_char;
                    idx_next   = in_idx;
                    is_rd_next = (in_cmd == trlp_pkg::CMD_READ);
                    state_next = S_DONE;
                    case (in_cmd)
                        trlp_pkg::CMD_CLEAR: begin
                            count_next = 8'd0;
                            phase_next = PH_START;
                            acc_next   = 9'd0;
                            rs_next    = 8'd0;
                            err_next   = trlp_pkg::STAT_OK;
                            kp_next    = 2'd0;
                            sweep_next = 8'd0;
                            state_next = S_CLEAR;
                        end
                        trlp_pkg::CMD_CHAR: begin
                            if (err_reg == trlp_pkg::STAT_OK) begin
                                case (phase_reg)
                                    PH_START, PH_FIRST, PH_EXPECT_END: begin
                                        if (phase_reg == PH_START && kp_reg != 2'd0) begin
                                            // Inside or after the keyword
                                            if (kp_reg == 2'd3) begin
                                                if (!c_space) begin
                                                    err_next = trlp_pkg::STAT_INVALID;
                                                end
                                            end else if (in_char == trlp_pkg::CH_L) begin
                                                kp_next = kp_reg + 2'd1;
                                            end else begin
                                                err_next = trlp_pkg::STAT_INVALID;
                                            end
                                        end else if (phase_reg == PH_START
                                                     && in_char == trlp_pkg::CH_A) begin
                                            kp_next = 2'd1;
                                        end else if (c_digit) begin
                                            // Open a number
                                            acc_next   = 9'(c_dval);
                                            phase_next = (phase_reg == PH_EXPECT_END)
                                                         ? PH_IN_END : PH_IN_START;
                                        end else if (!c_space) begin
                                            err_next = trlp_pkg::STAT_INVALID;
                                        end
                                    end
                                    PH_IN_START: begin
                                        if (c_digit) begin
                                            acc_next = acc_sat;
                                        end else if (!acc_ok) begin
                                            err_next = trlp_pkg::STAT_NOT_FOUND;
                                        end else begin
                                            rs_next    = acc_reg[7:0];
                                            phase_next = PH_AFTER_START;
                                            if (in_char == trlp_pkg::CH_DASH) begin
                                                phase_next = PH_EXPECT_END;
                                            end else if (!c_space) begin
                                                t_next      = acc_reg[7:0];
                                                end_next    = acc_reg[7:0];
                                                up_next     = 1'b0;
                                                follow_next = FL_AFTER_START;
                                                state_next  = S_EXP_RD;
                                            end
                                        end
                                    end
                                    PH_AFTER_START: begin
                                        if (in_char == trlp_pkg::CH_DASH) begin
                                            phase_next = PH_EXPECT_END;
                                        end else if (!c_space) begin
                                            t_next      = rs_reg;
                                            end_next    = rs_reg;
                                            up_next     = 1'b0;
                                            follow_next = FL_AFTER_START;
                                            state_next  = S_EXP_RD;
                                        end
                                    end
                                    PH_IN_END: begin
                                        if (c_digit) begin
                                            acc_next = acc_sat;
                                        end else if (!acc_ok) begin
                                            err_next = trlp_pkg::STAT_NOT_FOUND;
                                        end else begin
                                            t_next      = rs_reg;
                                            end_next    = acc_reg[7:0];
                                            up_next     = ({1'b0, rs_reg} < acc_reg);
                                            follow_next = FL_DELIM;
                                            state_next  = S_EXP_RD;
                                        end
                                    end
                                    PH_DELIM: begin
                                        if (in_char == trlp_pkg::CH_COMMA) begin
                                            phase_next = PH_FIRST;
                                        end else if (!c_space) begin
                                            err_next = trlp_pkg::STAT_INVALID;
                                        end
                                    end
                                    default: begin
                                    end
                                endcase
                            end
                        end
                        trlp_pkg::CMD_END: begin
                            if (err_reg == trlp_pkg::STAT_OK && phase_reg != PH_DONE) begin
                                follow_next = FL_END;
                                state_next  = S_FOLLOW;
                                case (phase_reg)
                                    PH_START: begin
                                        if (kp_reg == 2'd3) begin
                                            if (top_track_reg != 8'd0) begin
                                                t_next     = 8'd1;
                                                end_next   = top_track_reg;
                                                up_next    = (top_track_reg > 8'd1);
                                                state_next = S_EXP_RD;
                                            end
                                        end else if (kp_reg != 2'd0) begin
                                            err_next = trlp_pkg::STAT_INVALID;
                                        end
                                    end
                                    PH_IN_START: begin
                                        if (!acc_ok) begin
                                            err_next = trlp_pkg::STAT_NOT_FOUND;
                                        end else begin
                                            t_next     = acc_reg[7:0];
                                            end_next   = acc_reg[7:0];
                                            up_next    = 1'b0;
                                            state_next = S_EXP_RD;
                                        end
                                    end
                                    PH_AFTER_START: begin
                                        t_next     = rs_reg;
                                        end_next   = rs_reg;
                                        up_next    = 1'b0;
                                        state_next = S_EXP_RD;
                                    end
                                    PH_EXPECT_END: begin
                                        err_next = trlp_pkg::STAT_INVALID;
                                    end
                                    PH_IN_END: begin
                                        if (!acc_ok) begin
                                            err_next = trlp_pkg::STAT_NOT_FOUND;
                                        end else begin
                                            t_next     = rs_reg;
                                            end_next   = acc_reg[7:0];
                                            up_next    = ({1'b0, rs_reg} < acc_reg);
                                            state_next = S_EXP_RD;
                                        end
                                    end
                                    default: begin
                                    end
                                endcase
                            end
                        end
                        default: begin
                            // List read: memory address is the latched index
                            state_next = S_LIST_RD;
                        end
                    endcase
                end
            end
            S_LIST_RD: begin
                state_next = S_DONE;
            end
            S_EXP_RD: begin
                // Presence bit of the current track is read at this edge
                state_next = S_EXP_CHK;
            end
            S_EXP_CHK: begin
                if (add_new && count_reg >= 8'(LIST_DEPTH)) begin
                    err_next   = trlp_pkg::STAT_FULL;
                    state_next = S_FOLLOW;
                end else begin
                    if (add_new) begin
                        req.pm_we   = 1'b1;
                        req.pm_wbit = 1'b1;
                        req.list_we = 1'b1;
                        count_next  = count_reg + 8'd1;
                    end
                    if (t_reg == end_reg) begin
                        state_next = S_FOLLOW;
                    end else begin
                        t_next     = up_reg ? t_reg + 8'd1 : t_reg - 8'd1;
                        state_next = S_EXP_RD;
                    end
                end
            end
            S_FOLLOW: begin
                state_next = S_DONE;
                if (follow_reg == FL_END) begin
                    phase_next = PH_DONE;
                end
                if (err_reg == trlp_pkg::STAT_OK) begin
                    case (follow_reg)
                        FL_AFTER_START: begin
                            if (char_reg == trlp_pkg::CH_COMMA) begin
                                phase_next = PH_FIRST;
                            end else begin
                                err_next = trlp_pkg::STAT_INVALID;
                            end
                        end
                        FL_DELIM: begin
                            phase_next = PH_DELIM;
                            if (char_reg == trlp_pkg::CH_COMMA) begin
                                phase_next = PH_FIRST;
                            end else if (!is_space(char_reg)) begin
                                err_next = trlp_pkg::STAT_INVALID;
                            end
                        end
                        default: begin
                            if (count_reg == 8'd0) begin
                                err_next = trlp_pkg::STAT_INVALID;
                            end
                        end
                    endcase
                end
            end
            S_DONE: begin
                // Hold until the result register is free
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {6'd0, entry, count_reg, err_reg};
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State, parser registers and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_INIT;
            phase_reg     <= PH_START;
            top_track_reg <= 8'd255;
            count_reg     <= 8'd0;
            acc_reg       <= 9'd0;
            rs_reg        <= 8'd0;
            err_reg       <= trlp_pkg::STAT_OK;
            kp_reg        <= 2'd0;
            sweep_reg     <= 8'd0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            top_track_reg <= top_track_next;
            count_reg     <= count_next;
            acc_reg       <= acc_next;
            rs_reg        <= rs_next;
            err_reg       <= err_next;
            kp_reg        <= kp_next;
            sweep_reg     <= sweep_next;
            m_valid_reg   <= m_valid_next;
        end
        follow_reg <= follow_next;
        char_reg   <= char_next;
        idx_reg    <= idx_next;
        is_rd_reg  <= is_rd_next;
        t_reg      <= t_next;
        end_reg    <= end_next;
        up_reg     <= up_next;
        m_data_reg <= m_data_next;
    end

endmodule

// ===== design/trlp_checker.sv =====
// Port-level checks for track_range_list_parser, attached by the bind at the end.
// Depends on trlp_pkg for status codes.
module trlp_checker #(
    parameter int LIST_DEPTH = 255
) (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata
);

    // Reset drops the result and holds off input for the clearing pass
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && !s_tready)
        else $error("result or ready active right after reset");

    // A stalled result beat holds its payload
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // Ready drops once a beat is accepted
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("ready again right after an accepted beat");

    // List full is only reported with a full list
    a_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[1:0] == trlp_pkg::STAT_FULL |-> m_tdata[9:2] == 8'(LIST_DEPTH))
        else $error("list full reported with a partial list");

endmodule

bind track_range_list_parser trlp_checker #(.LIST_DEPTH(LIST_DEPTH)) u_trlp_checker (.*);

// ===== tb/sv/tb_track_range_list_parser.sv =====
// Self-checking testbench for track_range_list_parser: a directed script of
// selection texts, then random texts and list reads checked against a local
// model of the parser. Depends on trlp_pkg and the track_range_list_parser RTL.
`timescale 1ns / 100ps

module tb_track_range_list_parser;

    localparam int LIST_DEPTH = 255;
    localparam int unsigned CYCLE_LIMIT = 3_000_000;
    localparam int DRAIN_CYCLES = 600;
    localparam int BEATS_PER_PHASE = 150;
    localparam int NUM_PHASES = 6;

    // Parse stages of the selection text
    typedef enum logic [2:0] {
        LOOK_START, LOOK_NUM, IN_FROM, AFTER_FROM, LOOK_TO, IN_TO, LOOK_COMMA, TEXT_DONE
    } stage_t;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] count;
        logic [7:0] entry;
    } parse_result_t;

    typedef struct {
        logic [1:0]    cmd;
        logic [7:0]    ch;
        logic [7:0]    idx;
        bit            typed;
        parse_result_t want;
    } script_row_t;

    logic        aclk;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [7:0]  cfg_wdata = 8'd0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = 24'd0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;

    // Model of the selection state
    logic [7:0]  sel_tracks [LIST_DEPTH];
    bit          picked [256];
    int unsigned n_picked = 0;
    stage_t      stage = LOOK_START;
    int unsigned acc_value = 0;
    int unsigned from_track = 0;
    logic [1:0]  sticky_status = trlp_pkg::STAT_OK;
    int unsigned kw_seen = 0;
    int unsigned top_track = 255;

    parse_result_t expected_reports [$];
    script_row_t   script [$];
    logic [7:0]    spec_q [$];
    int unsigned   total_beats = 0;
    int unsigned   cycle_count = 0;
    int            mismatches = 0;
    bit            steady = 1'b0;

    track_range_list_parser #(
        .LIST_DEPTH(LIST_DEPTH)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // ---------------------------------------------------------------- model

    function automatic bit is_blank(logic [7:0] c);
        return c == trlp_pkg::CH_SPACE || (c >= trlp_pkg::CH_TAB && c <= trlp_pkg::CH_CR);
    endfunction

    function automatic bit is_digit(logic [7:0] c);
        return c >= trlp_pkg::CH_ZERO && c <= trlp_pkg::CH_NINE;
    endfunction

    // Saturate instead of wrapping on long digit strings
    function automatic void accumulate(logic [7:0] c);
        int unsigned v;
        v = acc_value * 10 + (c - trlp_pkg::CH_ZERO);
        acc_value = (v > trlp_pkg::ACC_MAX) ? trlp_pkg::ACC_MAX : v;
    endfunction

    function automatic bit in_range();
        return acc_value >= 1 && acc_value <= top_track;
    endfunction

    function automatic void add_track(int unsigned t);
        t = t & 255;
        if (t == 0 || picked[t])
            return;
        if (n_picked >= LIST_DEPTH) begin
            sticky_status = trlp_pkg::STAT_FULL;
            return;
        end
        sel_tracks[n_picked] = t[7:0];
        n_picked++;
        picked[t] = 1'b1;
    endfunction

    // Walk forward or backward, stop on the first error
    function automatic void add_range(int unsigned a, int unsigned b);
        int unsigned t;
        t = a;
        while (1) begin
            add_track(t);
            if (sticky_status != trlp_pkg::STAT_OK || t == b)
                return;
            if (a < b)
                t++;
            else
                t--;
        end
    endfunction

    function automatic void after_from(logic [7:0] c);
        if (is_blank(c))
            return;
        if (c == trlp_pkg::CH_DASH) begin
            stage = LOOK_TO;
            return;
        end
        add_track(from_track);
        if (sticky_status != trlp_pkg::STAT_OK)
            return;
        if (c == trlp_pkg::CH_COMMA)
            stage = LOOK_NUM;
        else
            sticky_status = trlp_pkg::STAT_INVALID;
    endfunction

    function automatic void comma_char(logic [7:0] c);
        if (is_blank(c))
            return;
        if (c == trlp_pkg::CH_COMMA)
            stage = LOOK_NUM;
        else
            sticky_status = trlp_pkg::STAT_INVALID;
    endfunction

    function automatic void open_number(logic [7:0] c, stage_t next);
        if (is_blank(c))
            return;
        if (is_digit(c)) begin
            acc_value = 0;
            accumulate(c);
            stage = next;
        end else begin
            sticky_status = trlp_pkg::STAT_INVALID;
        end
    endfunction

    function automatic void take_char(logic [7:0] c);
        case (stage)
            LOOK_START: begin
                if (kw_seen == 0) begin
                    if (c == trlp_pkg::CH_A)
                        kw_seen = 1;
                    else
                        open_number(c, IN_FROM);
                end else if (kw_seen < 3) begin
                    // both remaining keyword letters are 'l'
                    if (c == trlp_pkg::CH_L)
                        kw_seen++;
                    else
                        sticky_status = trlp_pkg::STAT_INVALID;
                end else if (!is_blank(c)) begin
                    sticky_status = trlp_pkg::STAT_INVALID;
                end
            end
            LOOK_NUM: open_number(c, IN_FROM);
            IN_FROM: begin
                if (is_digit(c)) begin
                    accumulate(c);
                end else if (!in_range()) begin
                    sticky_status = trlp_pkg::STAT_NOT_FOUND;
                end else begin
                    from_track = acc_value;
                    stage = AFTER_FROM;
                    after_from(c);
                end
            end
            AFTER_FROM: after_from(c);
            LOOK_TO: open_number(c, IN_TO);
            IN_TO: begin
                if (is_digit(c)) begin
                    accumulate(c);
                end else if (!in_range()) begin
                    sticky_status = trlp_pkg::STAT_NOT_FOUND;
                end else begin
                    add_range(from_track, acc_value);
                    if (sticky_status == trlp_pkg::STAT_OK) begin
                        stage = LOOK_COMMA;
                        comma_char(c);
                    end
                end
            end
            LOOK_COMMA: comma_char(c);
            default: ;
        endcase
    endfunction

    function automatic void close_text();
        case (stage)
            LOOK_START: begin
                if (kw_seen == 3) begin
                    if (top_track >= 1)
                        add_range(1, top_track);
                end else if (kw_seen != 0) begin
                    sticky_status = trlp_pkg::STAT_INVALID;
                end
            end
            IN_FROM: begin
                if (!in_range())
                    sticky_status = trlp_pkg::STAT_NOT_FOUND;
                else
                    add_track(acc_value);
            end
            AFTER_FROM: add_track(from_track);
            LOOK_TO: sticky_status = trlp_pkg::STAT_INVALID;
            IN_TO: begin
                if (!in_range())
                    sticky_status = trlp_pkg::STAT_NOT_FOUND;
                else
                    add_range(from_track, acc_value);
            end
            TEXT_DONE: return;
            default: ;
        endcase
        // a text that selects nothing is malformed
        if (sticky_status == trlp_pkg::STAT_OK && n_picked == 0)
            sticky_status = trlp_pkg::STAT_INVALID;
        stage = TEXT_DONE;
    endfunction

    function automatic void clear_selection();
        for (int t = 0; t < 256; t++)
            picked[t] = 1'b0;
        n_picked = 0;
        stage = LOOK_START;
        acc_value = 0;
        from_track = 0;
        sticky_status = trlp_pkg::STAT_OK;
        kw_seen = 0;
    endfunction

    function automatic parse_result_t selection_step(logic [1:0] cmd, logic [7:0] ch,
                                                     logic [7:0] idx);
        parse_result_t r;
        r.entry = 8'd0;
        case (cmd)
            trlp_pkg::CMD_CLEAR: clear_selection();
            trlp_pkg::CMD_CHAR:  if (sticky_status == trlp_pkg::STAT_OK) take_char(ch);
            trlp_pkg::CMD_END:   if (sticky_status == trlp_pkg::STAT_OK) close_text();
            default:             if (idx < n_picked) r.entry = sel_tracks[idx];
        endcase
        r.status = sticky_status;
        r.count = n_picked[7:0];
        return r;
    endfunction

    // ------------------------------------------------------------ stimulus

    // Start at a falling edge, hold the beat until accepted, return at the next falling edge
    task automatic send_beat(input logic [1:0] cmd, input logic [7:0] ch,
                             input logic [7:0] idx, input bit typed = 1'b0,
                             input parse_result_t want = '0);
        parse_result_t predicted;
        while (!steady && $urandom_range(99) < 15) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {6'd0, idx, ch, cmd};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        predicted = selection_step(cmd, ch, idx);
        expected_reports.push_back(typed ? want : predicted);
        total_beats++;
        @(negedge aclk);
    endtask

    // Write the top track number only once every pending result is back
    task automatic write_top_track(input int unsigned v);
        s_tvalid <= 1'b0;
        while (expected_reports.size() != 0)
            @(posedge aclk);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= v[7:0];
        @(negedge aclk);
        cfg_we <= 1'b0;
        top_track = v;
    endtask

    function automatic void row(logic [1:0] cmd, logic [7:0] ch, logic [7:0] idx, bit typed,
                                logic [1:0] st, logic [7:0] cnt, logic [7:0] ent);
        script_row_t r;
        r.cmd = cmd;
        r.ch = ch;
        r.idx = idx;
        r.typed = typed;
        r.want.status = st;
        r.want.count = cnt;
        r.want.entry = ent;
        script.push_back(r);
    endfunction

    function automatic void text_rows(string s);
        for (int i = 0; i < s.len(); i++)
            row(trlp_pkg::CMD_CHAR, s[i], 8'd0, 1'b0, trlp_pkg::STAT_OK, 8'd0, 8'd0);
    endfunction

    function automatic logic [7:0] blank_char();
        int unsigned n;
        n = $urandom_range(0, 5);
        return (n == 5) ? trlp_pkg::CH_SPACE : trlp_pkg::CH_TAB + 8'(n);
    endfunction

    function automatic void put_blank();
        if ($urandom_range(99) < 20)
            spec_q.push_back(blank_char());
    endfunction

    function automatic void put_number(int unsigned v);
        string digits;
        digits = $sformatf("%0d", v);
        if ($urandom_range(99) < 8)
            spec_q.push_back(trlp_pkg::CH_ZERO);
        for (int i = 0; i < digits.len(); i++)
            spec_q.push_back(digits[i]);
    endfunction

    // Mostly existing tracks, some zero, some past the end, some that saturate
    function automatic int unsigned pick_number();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 86)
            return $urandom_range(1, top_track);
        if (r < 91)
            return 0;
        if (r < 95)
            return top_track + $urandom_range(1, 20);
        return $urandom_range(256, 99999);
    endfunction

    function automatic void build_list();
        int unsigned terms;
        terms = $urandom_range(1, 4);
        for (int t = 0; t < terms; t++) begin
            put_blank();
            put_number(pick_number());
            put_blank();
            if ($urandom_range(99) < 40) begin
                spec_q.push_back(trlp_pkg::CH_DASH);
                put_blank();
                put_number(pick_number());
                put_blank();
            end
            if (t != terms - 1)
                spec_q.push_back(trlp_pkg::CH_COMMA);
        end
        if ($urandom_range(99) < 10)
            spec_q.push_back(trlp_pkg::CH_COMMA);
    endfunction

    function automatic void build_all();
        spec_q.push_back(trlp_pkg::CH_A);
        spec_q.push_back(trlp_pkg::CH_L);
        spec_q.push_back(trlp_pkg::CH_L);
        repeat ($urandom_range(0, 2))
            spec_q.push_back(blank_char());
        // spoil the keyword now and then
        if ($urandom_range(99) < 25) begin
            case ($urandom_range(2))
                0: while (spec_q.size() > $urandom_range(1, 2)) void'(spec_q.pop_back());
                1: spec_q.push_back(trlp_pkg::CH_ZERO + 8'($urandom_range(1, 9)));
                default: spec_q[$urandom_range(1, 2)] = 8'($urandom);
            endcase
        end
    endfunction

    // One selection: clear, text, end, stray beats, then list reads
    task automatic run_sequence();
        int unsigned kind;
        int unsigned pos;
        logic [7:0] idx;
        spec_q.delete();
        kind = $urandom_range(99);
        if (kind < 60) begin
            build_list();
        end else if (kind < 72) begin
            build_all();
        end else if (kind < 87) begin
            build_list();
            pos = $urandom_range(0, spec_q.size() - 1);
            case ($urandom_range(3))
                0: spec_q.insert(pos, trlp_pkg::CH_DASH);
                1: spec_q.insert(pos, trlp_pkg::CH_COMMA);
                2: spec_q.insert(pos, trlp_pkg::CH_A);
                default: spec_q[pos] = 8'($urandom);
            endcase
        end else begin
            repeat ($urandom_range(1, 8))
                spec_q.push_back(($urandom_range(9) == 0) ? 8'h00 : 8'($urandom));
        end

        if ($urandom_range(99) < 92)
            send_beat(trlp_pkg::CMD_CLEAR, 8'($urandom), 8'($urandom));
        foreach (spec_q[i])
            send_beat(trlp_pkg::CMD_CHAR, spec_q[i], 8'($urandom));
        send_beat(trlp_pkg::CMD_END, 8'($urandom), 8'($urandom));
        // text after the end is ignored until the next clear
        if ($urandom_range(99) < 15) begin
            send_beat(trlp_pkg::CMD_CHAR, trlp_pkg::CH_ZERO + 8'($urandom_range(1, 9)),
                      8'($urandom));
            send_beat(trlp_pkg::CMD_END, 8'($urandom), 8'($urandom));
        end
        repeat ($urandom_range(1, 3)) begin
            if (n_picked == 0 || $urandom_range(99) < 20)
                idx = 8'($urandom_range(0, LIST_DEPTH - 1));
            else
                idx = 8'($urandom_range(0, n_picked - 1));
            send_beat(trlp_pkg::CMD_READ, 8'($urandom), idx);
        end
    endtask

    // ------------------------------------------------------------ main flow

    initial begin
        int unsigned phase_end;
        int unsigned top;

        row(trlp_pkg::CMD_READ, 8'd0, 8'd0, 1'b1, trlp_pkg::STAT_OK, 8'd0, 8'd0);
        row(trlp_pkg::CMD_CLEAR, 8'd0, 8'd0, 1'b1, trlp_pkg::STAT_OK, 8'd0, 8'd0);
        text_rows("1-3, 5,9-7,");
        row(trlp_pkg::CMD_END, 8'd0, 8'd0, 1'b0, trlp_pkg::STAT_OK, 8'd0, 8'd0);
        row(trlp_pkg::CMD_READ, 8'd0, 8'd254, 1'b1, trlp_pkg::STAT_OK, 8'd7, 8'd0);
        row(trlp_pkg::CMD_CLEAR, 8'd0, 8'd0, 1'b1, trlp_pkg::STAT_OK, 8'd0, 8'd0);
        row(trlp_pkg::CMD_CHAR, trlp_pkg::CH_ZERO, 8'd0, 1'b0, trlp_pkg::STAT_OK, 8'd0, 8'd0);
        row(trlp_pkg::CMD_END, 8'd0, 8'd0, 1'b1, trlp_pkg::STAT_NOT_FOUND, 8'd0, 8'd0);
        row(trlp_pkg::CMD_CLEAR, 8'd0, 8'd0, 1'b1, trlp_pkg::STAT_OK, 8'd0, 8'd0);
        row(trlp_pkg::CMD_CHAR, 8'hFF, 8'd0, 1'b1, trlp_pkg::STAT_INVALID, 8'd0, 8'd0);
        row(trlp_pkg::CMD_CLEAR, 8'd0, 8'd0, 1'b1, trlp_pkg::STAT_OK, 8'd0, 8'd0);
        text_rows("all");
        row(trlp_pkg::CMD_END, 8'd0, 8'd0, 1'b1, trlp_pkg::STAT_OK, 8'd255, 8'd0);
        row(trlp_pkg::CMD_READ, 8'd0, 8'd254, 1'b1, trlp_pkg::STAT_OK, 8'd255, 8'd255);

        // hold reset, then release on a falling edge
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (script[i])
            send_beat(script[i].cmd, script[i].ch, script[i].idx, script[i].typed,
                      script[i].want);

        // random phases, each under its own top track number
        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0: top = 1;
                1: top = $urandom_range(2, 254);
                2: top = 255;
                3: top = $urandom_range(2, 40);
                4: top = 255;
                default: top = $urandom_range(1, 255);
            endcase
            write_top_track(top);
            steady = (p == 3);
            phase_end = total_beats + BEATS_PER_PHASE;
            while (total_beats < phase_end)
                run_sequence();
        end
        steady = 1'b0;

        // drain, then give the block time to show any stray beat
        s_tvalid <= 1'b0;
        while (expected_reports.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0 && expected_reports.size() == 0)
            $display("tb_track_range_list_parser OK");
        else
            $display("tb_track_range_list_parser NOT OK");
        $finish;
    end

    // Stall the result side at random
    always @(negedge aclk) begin
        m_tready <= steady ? 1'b1 : ($urandom_range(99) >= 15);
    end

    // Compare each result beat with the oldest expectation
    always @(posedge aclk) begin
        parse_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_reports.size() == 0) begin
                $error("result beat with no request pending: tdata %h", m_tdata);
                mismatches++;
            end else begin
                want = expected_reports.pop_front();
                if (m_tdata[1:0] !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_tdata[1:0]);
                    mismatches++;
                end
                if (m_tdata[9:2] !== want.count) begin
                    $error("track_count: expected %0d, got %0d", want.count, m_tdata[9:2]);
                    mismatches++;
                end
                if (m_tdata[17:10] !== want.entry) begin
                    $error("entry_track: expected %0d, got %0d", want.entry, m_tdata[17:10]);
                    mismatches++;
                end
            end
        end
    end

    // Abort a hung run
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_track_range_list_parser NOT OK");
            $finish;
        end
    end

endmodule
